>>> design/modular_matrix_power_sum_core_macros.svh
// ----------------------------------------------------------------------------
// modular_matrix_power_sum_core_macros.svh
// assertion macros shared by the matrix power sum core
// ----------------------------------------------------------------------------
`ifndef MODULAR_MATRIX_POWER_SUM_CORE_MACROS_SVH
`define MODULAR_MATRIX_POWER_SUM_CORE_MACROS_SVH

// condition a implies condition b in the same cycle
`define MMPS_ASSERT_SAME(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// condition a implies condition b in the next cycle
`define MMPS_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

>>> design/mmps_pkg.sv
// ----------------------------------------------------------------------------
// mmps_pkg
// constants and modular helpers for the matrix power sum core
// ----------------------------------------------------------------------------
package mmps_pkg;

  localparam int VAL_W = 30;
  localparam int DIM_W = 5;
  localparam int EXP_W = 60;

  typedef logic [VAL_W-1:0] value_t;

  localparam value_t MODULUS = 30'd1000000007;

  // configuration register indexes
  localparam logic REG_DIM = 1'b0;
  localparam logic REG_EXP = 1'b1;

  // bring a raw 30-bit value into range (it is always below twice the modulus)
  function automatic value_t mod_fix(input value_t x);
    mod_fix = (x >= MODULUS) ? value_t'(x - MODULUS) : x;
  endfunction

  // sum of two residues, reduced
  function automatic value_t mod_add(input value_t a, input value_t b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    mod_add = (s >= {1'b0, MODULUS}) ? value_t'(s - {1'b0, MODULUS}) : value_t'(s);
  endfunction

endpackage

>>> design/mmps_ram.sv
// ----------------------------------------------------------------------------
// mmps_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module mmps_ram #(
  parameter int WIDTH  = 30,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/modular_matrix_power_sum_core.sv
// ----------------------------------------------------------------------------
// modular_matrix_power_sum_core
// loads a square matrix, raises it to a power mod 1e9+7 by repeated
// squaring and returns the modular sum of all entries of the power
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  in        sink       entry_value, final_entry
//  out       source     walk_total
//  cfg       sink       cfg_index, cfg_data (dimension, exponent)
//
// the core keeps loading after a non-final entry beat. after the final beat:
// an init sweep over the n*n cells, then per exponent bit a decision state
// and one or two products of n^3 bit-serial multiplies (two fetches, load,
// a shift-add step per bit of the 30-bit multiplier, add), each followed by
// an n*n copy sweep, then an n*n summing sweep; every sweep ends in a drain
// state. a dimension write while loading stalls input during the remap.
// reset is synchronous; in_stall is high whenever no entry can be taken.
`include "modular_matrix_power_sum_core_macros.svh"

module modular_matrix_power_sum_core
  import mmps_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [29:0]      entry_value,
  input  logic             final_entry,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [29:0]      walk_total,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [EXP_W-1:0] cfg_data
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW    = $clog2(CELLS + 1);
  localparam int NW    = $clog2(MAX_DIM + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_REMAP = 4'd1;
  localparam logic [3:0] S_SWEEP = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_BIT   = 4'd4;
  localparam logic [3:0] S_FX    = 4'd5;
  localparam logic [3:0] S_FY    = 4'd6;
  localparam logic [3:0] S_OPS   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_ADD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic [1:0] K_INIT = 2'd0;
  localparam logic [1:0] K_CPOW = 2'd1;
  localparam logic [1:0] K_CSCR = 2'd2;
  localparam logic [1:0] K_SUM  = 2'd3;

  localparam logic [4:0] TOP_BIT = 5'(VAL_W - 1);

  logic [3:0]       state;
  logic [1:0]       kind;
  logic [DIM_W-1:0] dimension;
  logic [EXP_W-1:0] exponent;
  logic [EXP_W-1:0] rem;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    lrow;
  logic [PW-1:0]    lcol;
  logic [NW-1:0]    mr;
  logic [NW-1:0]    mc;
  logic [NW-1:0]    mt;
  logic [4:0]       mb;
  logic             mulpow;
  value_t           xop;
  value_t           yop;
  value_t           tm;
  value_t           acc;
  value_t           total;
  logic             pend;
  logic             pend_diag;
  logic [AW-1:0]    pend_addr;

  logic [NW-1:0]    n;
  logic [PW-1:0]    nn;
  logic             in_fire;
  logic             load_ok;
  logic             rc_last;
  logic             c_wrap;
  logic             t_last;
  value_t           acc_sum;
  logic [AW-1:0]    a_rc;
  logic [AW-1:0]    a_rt;
  logic [AW-1:0]    a_tc;
  logic [AW-1:0]    a_load;

  logic             base_we;
  logic             pow_we;
  logic             scr_we;
  logic             prod_we;
  value_t           pow_wdata;
  value_t           scr_wdata;
  logic [AW-1:0]    pow_raddr;
  logic [AW-1:0]    scr_raddr;
  logic [AW-1:0]    pow_waddr;
  logic [AW-1:0]    scr_waddr;
  value_t           base_rd;
  value_t           pow_rd;
  value_t           scr_rd;
  value_t           prod_rd;

  function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] r,
                                              input logic [NW-1:0] c);
    cell_addr = AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
  endfunction

  // dimension in use, clamped to 1..MAX_DIM
  always_comb begin
    if (dimension == '0) begin
      n = NW'(1);
    end else if (int'(dimension) > MAX_DIM) begin
      n = NW'(MAX_DIM);
    end else begin
      n = NW'(dimension);
    end
  end

  assign nn       = PW'(PW'(n) * PW'(n));
  assign in_stall = (state != S_LOAD);
  assign in_fire  = in_valid && !in_stall;
  assign load_ok  = (pos < nn);
  assign out_valid  = (state == S_OUT);
  assign walk_total = total;

  // loop position helpers
  assign c_wrap  = (mc == n - NW'(1));
  assign rc_last = c_wrap && (mr == n - NW'(1));
  assign t_last  = (mt == n - NW'(1));
  assign acc_sum = mod_add(acc, tm);

  assign a_rc   = cell_addr(mr, mc);
  assign a_rt   = cell_addr(mr, mt);
  assign a_tc   = cell_addr(mt, mc);
  assign a_load = cell_addr(NW'(lrow), NW'(lcol));

  // memory port control
  always_comb begin
    base_we   = in_fire && load_ok;
    prod_we   = (state == S_ADD) && t_last;
    pow_we    = pend && ((kind == K_INIT) || (kind == K_CPOW));
    scr_we    = pend && ((kind == K_INIT) || (kind == K_CSCR));
    pow_wdata = (kind == K_INIT) ? (pend_diag ? value_t'(1) : '0) : prod_rd;
    scr_wdata = (kind == K_INIT) ? base_rd : prod_rd;
    pow_waddr = pend_addr;
    scr_waddr = pend_addr;
    pow_raddr = (state == S_FX) ? a_rt : a_rc;
    case (state)
      S_FX:    scr_raddr = a_rt;
      S_FY:    scr_raddr = a_tc;
      default: scr_raddr = a_rc;
    endcase
  end

  mmps_ram #(.WIDTH(VAL_W), .DEPTH(CELLS), .ADDR_W(AW)) u_base (
    .clk(clk), .we(base_we), .waddr(a_load), .wdata(mod_fix(entry_value)),
    .raddr(a_rc), .rdata(base_rd)
  );

  mmps_ram #(.WIDTH(VAL_W), .DEPTH(CELLS), .ADDR_W(AW)) u_power (
    .clk(clk), .we(pow_we), .waddr(pow_waddr), .wdata(pow_wdata),
    .raddr(pow_raddr), .rdata(pow_rd)
  );

  mmps_ram #(.WIDTH(VAL_W), .DEPTH(CELLS), .ADDR_W(AW)) u_scratch (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rd)
  );

  mmps_ram #(.WIDTH(VAL_W), .DEPTH(CELLS), .ADDR_W(AW)) u_prod (
    .clk(clk), .we(prod_we), .waddr(a_rc), .wdata(acc_sum),
    .raddr(a_rc), .rdata(prod_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      kind      <= K_INIT;
      dimension <= DIM_W'(1);
      exponent  <= EXP_W'(1);
      rem       <= '0;
      pos       <= '0;
      lrow      <= '0;
      lcol      <= '0;
      mr        <= '0;
      mc        <= '0;
      mt        <= '0;
      mb        <= '0;
      mulpow    <= 1'b0;
      acc       <= '0;
      total     <= '0;
      pend      <= 1'b0;
    end else begin
      pend      <= (state == S_SWEEP);
      pend_addr <= a_rc;
      pend_diag <= (mr == mc);

      // summing sweep takes data in the cycle after the read
      if (pend && (kind == K_SUM)) begin
        total <= mod_add(total, pow_rd);
      end

      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (load_ok) begin
              pos <= pos + PW'(1);
              if (lcol + PW'(1) == PW'(n)) begin
                lcol <= '0;
                lrow <= lrow + PW'(1);
              end else begin
                lcol <= lcol + PW'(1);
              end
            end
            if (final_entry) begin
              pos   <= '0;
              lrow  <= '0;
              lcol  <= '0;
              rem   <= exponent;
              kind  <= K_INIT;
              mr    <= '0;
              mc    <= '0;
              state <= S_SWEEP;
            end
          end
        end
        S_REMAP: begin
          // row and column of the next entry under the new dimension
          if (lcol >= PW'(n)) begin
            lcol <= lcol - PW'(n);
            lrow <= lrow + PW'(1);
          end else begin
            state <= S_LOAD;
          end
        end
        S_SWEEP: begin
          if (rc_last) begin
            state <= S_DRAIN;
          end
          if (c_wrap) begin
            mc <= '0;
            mr <= mr + NW'(1);
          end else begin
            mc <= mc + NW'(1);
          end
        end
        S_DRAIN: begin
          mr  <= '0;
          mc  <= '0;
          mt  <= '0;
          acc <= '0;
          case (kind)
            K_INIT: state <= S_BIT;
            K_CPOW: begin
              mulpow <= 1'b0;
              state  <= S_FX;
            end
            K_CSCR: begin
              rem   <= rem >> 1;
              state <= S_BIT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_BIT: begin
          mr  <= '0;
          mc  <= '0;
          mt  <= '0;
          acc <= '0;
          if (rem == '0) begin
            kind  <= K_SUM;
            total <= '0;
            state <= S_SWEEP;
          end else begin
            mulpow <= rem[0];
            state  <= S_FX;
          end
        end
        S_FX: state <= S_FY;
        S_FY: begin
          xop   <= mulpow ? pow_rd : scr_rd;
          state <= S_OPS;
        end
        S_OPS: begin
          yop   <= scr_rd;
          tm    <= '0;
          mb    <= TOP_BIT;
          state <= S_MUL;
        end
        S_MUL: begin
          // one multiplier bit per cycle, msb first
          tm <= mod_add(mod_add(tm, tm), xop[mb] ? yop : '0);
          if (mb == '0) begin
            state <= S_ADD;
          end else begin
            mb <= mb - 5'd1;
          end
        end
        S_ADD: begin
          if (t_last) begin
            acc <= '0;
            mt  <= '0;
            if (c_wrap) begin
              mc <= '0;
              mr <= mr + NW'(1);
            end else begin
              mc <= mc + NW'(1);
            end
            if (rc_last) begin
              mr    <= '0;
              mc    <= '0;
              kind  <= mulpow ? K_CPOW : K_CSCR;
              state <= S_SWEEP;
            end else begin
              state <= S_FX;
            end
          end else begin
            acc   <= acc_sum;
            mt    <= mt + NW'(1);
            state <= S_FX;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase

      // configuration writes
      if (cfg_write) begin
        case (cfg_index)
          REG_DIM: begin
            dimension <= cfg_data[DIM_W-1:0];
            if ((state == S_LOAD) || (state == S_REMAP)) begin
              lrow  <= '0;
              lcol  <= pos;
              state <= S_REMAP;
            end
          end
          REG_EXP: exponent <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // checks
  `MMPS_ASSERT_SAME(a_total_range, clk, rst, out_valid, total < MODULUS, "result out of range")
  `MMPS_ASSERT_SAME(a_add_range, clk, rst, state == S_ADD, (tm < MODULUS) && (acc < MODULUS), "residue out of range")
  `MMPS_ASSERT_NEXT(a_final_starts, clk, rst, in_fire && final_entry && !cfg_write, state == S_SWEEP && kind == K_INIT, "final beat did not start")
  `MMPS_ASSERT_NEXT(a_pend_sweep, clk, rst, state == S_SWEEP, pend, "sweep write lost")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the matrix power sum core: matrices are streamed in row-major order
// under random idling on both channels, each result is compared against a
// local repeated-squaring predictor mod 1e9+7
// ----------------------------------------------------------------------------
module testbench;
  import mmps_pkg::*;

  localparam int  GRID = 16;
  localparam longint unsigned PRIME = 64'd1000000007;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [29:0]      entry_value;
  logic             final_entry;
  logic             out_valid;
  logic             out_stall;
  logic [29:0]      walk_total;
  logic             cfg_write;
  logic             cfg_index;
  logic [EXP_W-1:0] cfg_data;

  modular_matrix_power_sum_core #(.MAX_DIM(GRID)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .entry_value(entry_value), .final_entry(final_entry),
    .out_valid(out_valid), .out_stall(out_stall), .walk_total(walk_total),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  value_t             base_m  [GRID*GRID];
  value_t             pow_m   [GRID*GRID];
  value_t             scr_m   [GRID*GRID];
  value_t             prod_m  [GRID*GRID];
  int unsigned        load_pos;
  logic [DIM_W-1:0]   dim_reg;
  logic [EXP_W-1:0]   exp_reg;
  value_t             walk_expect[$];

  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int items_sent;

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // timeout
  initial begin
    #300_000_000;
    $display("FAIL modular_matrix_power_sum_core");
    $finish;
  end

  function automatic int unsigned dim_in_use();
    if (dim_reg == 0) return 1;
    if (dim_reg > GRID) return GRID;
    return dim_reg;
  endfunction

  // one entry of left * scratch, left being power or scratch
  function automatic value_t row_col(input bit left_pow, input int unsigned r,
                                     input int unsigned c, input int unsigned n);
    longint unsigned acc, a;
    acc = 0;
    for (int unsigned t = 0; t < n; t++) begin
      a = left_pow ? pow_m[r*GRID+t] : scr_m[r*GRID+t];
      acc = (acc + (a * scr_m[t*GRID+c]) % PRIME) % PRIME;
    end
    return value_t'(acc);
  endfunction

  // product into power (left_pow) or scratch squared
  function automatic void multiply_step(input bit left_pow, input int unsigned n);
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = 0; c < n; c++)
        prod_m[r*GRID+c] = row_col(left_pow, r, c, n);
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = 0; c < n; c++)
        if (left_pow) pow_m[r*GRID+c] = prod_m[r*GRID+c];
        else scr_m[r*GRID+c] = prod_m[r*GRID+c];
  endfunction

  // advance predictor on one accepted input beat
  function automatic void predict_walk_beat(input logic [29:0] raw, input bit fin);
    int unsigned n;
    logic [EXP_W-1:0] bits;
    longint unsigned sum;
    value_t v;
    n = dim_in_use();
    v = (raw >= 30'd1000000007) ? value_t'(raw - 30'd1000000007) : value_t'(raw);
    if (load_pos < n*n) begin
      base_m[(load_pos / n)*GRID + (load_pos % n)] = v;
      load_pos++;
    end
    if (!fin) return;
    load_pos = 0;
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = 0; c < n; c++) begin
        pow_m[r*GRID+c] = (r == c) ? 30'd1 : 30'd0;
        scr_m[r*GRID+c] = base_m[r*GRID+c];
      end
    bits = exp_reg;
    while (bits != 0) begin
      if (bits[0]) multiply_step(1'b1, n);
      multiply_step(1'b0, n);
      bits = bits >> 1;
    end
    sum = 0;
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = 0; c < n; c++)
        sum = (sum + pow_m[r*GRID+c]) % PRIME;
    walk_expect = {walk_expect, value_t'(sum)};
  endfunction

  // random entry: mostly residues, some corners and unreduced values
  function automatic logic [29:0] pick_entry();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return 30'($urandom_range(1000000006, 0));
    if (k < 80) return ($urandom_range(1)) ? 30'd1000000006 : 30'd0;
    if (k < 90) return 30'($urandom_range(32'h3FFF_FFFF, 1000000007));
    return 30'($urandom_range(3));
  endfunction

  // send one input beat, then maybe idle
  task automatic send_entry(input logic [29:0] v, input bit fin);
    in_valid    = 1'b1;
    entry_value = v;
    final_entry = fin;
    do @(posedge clk); while (in_stall);
    predict_walk_beat(v, fin);
    items_sent++;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      entry_value = pick_entry();
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
  endtask

  // stream a matrix: count entries, the last one a final beat
  task automatic send_matrix(input int unsigned count);
    for (int unsigned i = 1; i < count; i++) send_entry(pick_entry(), 1'b0);
    send_entry(pick_entry(), 1'b1);
  endtask

  // pause the sender until every expected result is back, then settle
  task automatic drain();
    in_valid = 1'b0;
    while (walk_expect.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [EXP_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data  = '0;
    if (idx == REG_DIM) dim_reg = data[DIM_W-1:0];
    else exp_reg = data;
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (walk_expect.size() == 0) begin
        $display("%0t: unexpected result walk_total=%0d", $time, walk_total);
        errors++;
      end else begin
        value_t want;
        want = walk_expect.pop_front();
        if (walk_total !== want) begin
          $display("%0t: walk_total mismatch expected=%0d actual=%0d",
                   $time, want, walk_total);
          errors++;
        end
      end
    end
  end

  // reset values: dimension 1, exponent 1
  task automatic test_reset_defaults();
    send_entry(30'd1000000006, 1'b1);
    send_entry(30'h3FFF_FFFF, 1'b1);
    drain();
  endtask

  // full-size matrix, clamped dimension, then dimension zero
  task automatic test_dimension_limits();
    write_reg(REG_DIM, 60'd31);
    send_matrix(GRID*GRID);
    drain();
    write_reg(REG_EXP, 60'd0);
    write_reg(REG_DIM, 60'd16);
    send_entry(30'd5, 1'b1);
    drain();
    write_reg(REG_EXP, 60'd3);
    write_reg(REG_DIM, 60'd0);
    send_entry(30'd1000000006, 1'b1);
    drain();
  endtask

  // exponent extremes on small matrices
  task automatic test_exponent_limits();
    write_reg(REG_DIM, 60'd2);
    write_reg(REG_EXP, 60'd0);
    send_matrix(4);
    drain();
    write_reg(REG_EXP, {EXP_W{1'b1}});
    send_entry(30'd1000000006, 1'b0);
    send_entry(30'd0, 1'b0);
    send_entry(30'h3FFF_FFFF, 1'b0);
    send_entry(30'd1, 1'b1);
    drain();
  endtask

  // surplus entries, early final, dimension change mid-load
  task automatic test_load_corners();
    write_reg(REG_EXP, 60'd5);
    send_matrix(7);
    send_matrix(2);
    drain();
    send_entry(30'd7, 1'b0);
    send_entry(30'd9, 1'b0);
    in_valid = 1'b0;
    repeat (40) @(negedge clk);
    write_reg(REG_DIM, 60'd3);
    send_matrix(7);
    drain();
  endtask

  // random matrices in groups sharing one setting
  task automatic test_random_walks(input int unsigned target, input bit squeeze);
    int unsigned stop_at, n, groups, k;
    logic [EXP_W-1:0] e;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      k = $urandom_range(99);
      n = (k < 40) ? 1 : (k < 75) ? 2 : 3;
      k = $urandom_range(99);
      if ((n == 1 && k < 25) || (n == 2 && k < 10))
        e = EXP_W'({$urandom, $urandom});
      else
        e = (n == 3) ? 60'($urandom_range(7)) : 60'($urandom_range(15));
      write_reg(REG_DIM, (n == 1 && $urandom_range(3) == 0) ? 60'd0 : 60'(n));
      write_reg(REG_EXP, e);
      groups = $urandom_range(5, 1);
      if (squeeze) begin
        hold_left = 3000;
        groups = 5;
        squeeze = 0;
      end
      for (int unsigned g = 0; g < groups; g++) begin
        k = $urandom_range(99);
        if (k < 8) send_matrix(n*n + $urandom_range(3, 1));
        else if (k < 16) send_matrix($urandom_range(n*n, 1));
        else send_matrix(n*n);
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    entry_value = '0;
    final_entry = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_DIM;
    cfg_data = '0;
    errors = 0;
    hold_left = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_pos = 0;
    dim_reg = 5'd1;
    exp_reg = 60'd1;
    for (int i = 0; i < GRID*GRID; i++) begin
      base_m[i] = '0; pow_m[i] = '0; scr_m[i] = '0; prod_m[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_dimension_limits();
    test_exponent_limits();
    test_load_corners();

    send_idle_pct = 7;  recv_idle_pct = 62;
    test_random_walks(280, 1'b0);
    send_idle_pct = 62; recv_idle_pct = 7;
    test_random_walks(280, 1'b0);
    send_idle_pct = 0;  recv_idle_pct = 0;
    test_random_walks(290, 1'b1);

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("PASS modular_matrix_power_sum_core");
    end else begin
      $display("FAIL modular_matrix_power_sum_core");
    end
    $finish;
  end

endmodule
